/* sv/mlfq_pkg.sv */
`default_nettype none
package mlfq_pkg;

   localparam int DEF_NUM_TASKS  = 64;
   localparam int DEF_NUM_LEVELS = 4;
   localparam int NUM_SLICES     = 4;

   localparam logic [2:0] ACT_ENQUEUE = 3'd0;
   localparam logic [2:0] ACT_REMOVE  = 3'd1;
   localparam logic [2:0] ACT_DEMOTE  = 3'd2;
   localparam logic [2:0] ACT_BOOST   = 3'd3;
   localparam logic [2:0] ACT_PICK    = 3'd4;

   localparam logic [15:0] SLICE0_RESET = 16'd5;
   localparam logic [15:0] SLICE1_RESET = 16'd10;
   localparam logic [15:0] SLICE2_RESET = 16'd20;
   localparam logic [15:0] SLICE3_RESET = 16'd40;

   typedef struct packed {
      logic [2:0] action;
      logic [5:0] task_number;
      logic [3:0] requested_level;
      logic [1:0] query_level;
   } req_type;

   typedef struct packed {
      logic [5:0]  result_task;
      logic [1:0]  result_level;
      logic [15:0] granted_slice;
      logic        found;
      logic        last;
      logic [6:0]  level_count;
   } rsp_type;

   typedef struct packed {
      logic next_we;
      logic prev_we;
      logic level_we;
   } link_we_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_APPEND_A,
      ST_APPEND_B,
      ST_BOOST,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

/* sv/mlfq_link_mem.sv */
`default_nettype none
module mlfq_link_mem #(
   parameter int NUM_TASKS  = mlfq_pkg::DEF_NUM_TASKS,
   parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS
) (
   input  wire logic                              clock,
   input  wire logic [$clog2(NUM_TASKS)-1:0]      rd_addr,
   output logic      [$clog2(NUM_TASKS+1)-1:0]    rd_next,
   output logic      [$clog2(NUM_TASKS+1)-1:0]    rd_prev,
   output logic      [$clog2(NUM_LEVELS)-1:0]     rd_level,
   input  mlfq_pkg::link_we_type                  wr_en,
   input  wire logic [$clog2(NUM_TASKS)-1:0]      next_addr,
   input  wire logic [$clog2(NUM_TASKS+1)-1:0]    next_data,
   input  wire logic [$clog2(NUM_TASKS)-1:0]      prev_addr,
   input  wire logic [$clog2(NUM_TASKS+1)-1:0]    prev_data,
   input  wire logic [$clog2(NUM_TASKS)-1:0]      level_addr,
   input  wire logic [$clog2(NUM_LEVELS)-1:0]     level_data
);
   import mlfq_pkg::*;

   localparam int LINK_W = $clog2(NUM_TASKS+1);
   localparam int LW     = $clog2(NUM_LEVELS);

   logic [LINK_W-1:0] next_mem  [NUM_TASKS];
   logic [LINK_W-1:0] prev_mem  [NUM_TASKS];
   logic [LW-1:0]     level_mem [NUM_TASKS];

   always_ff @(posedge clock) begin
      if (wr_en.next_we) begin
         next_mem[next_addr] <= next_data;
      end
      if (wr_en.prev_we) begin
         prev_mem[prev_addr] <= prev_data;
      end
      if (wr_en.level_we) begin
         level_mem[level_addr] <= level_data;
      end
      rd_next  <= next_mem[rd_addr];
      rd_prev  <= prev_mem[rd_addr];
      rd_level <= level_mem[rd_addr];
   end

endmodule
`default_nettype wire

/* sv/multilevel_feedback_queue_top.sv */
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  mlfq_pkg::req_type
// rsp       out        rsp_valid / rsp_stall  mlfq_pkg::rsp_type
// csr       in         psel/penable/pready    4 x 16-bit slice registers
//
// One item at a time; states after idle: enqueue append A/B, emit (lookup,
// emit if already queued); remove lookup, emit (emit alone if not queued);
// pick lookup, emit (emit alone if all empty); demote lookup, append A/B,
// emit; boost, per moved task, boost, lookup, append A/B, emit. A result
// waits only while the previous one is still stalled in the output register.
// Synchronous reset empties all levels and clears queued marks; the link
// memory is not cleared. A stalled result holds in the output register while
// the next item is taken.
module multilevel_feedback_queue_top #(
   parameter int NUM_TASKS  = mlfq_pkg::DEF_NUM_TASKS,
   parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  mlfq_pkg::req_type      req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mlfq_pkg::rsp_type      rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import mlfq_pkg::*;

   localparam int TW     = $clog2(NUM_TASKS);
   localparam int LINK_W = $clog2(NUM_TASKS+1);
   localparam int LW     = $clog2(NUM_LEVELS);
   localparam int CW     = $clog2(NUM_TASKS+1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_TASKS);

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [TW-1:0]     task_ff, task_in;
   logic [1:0]        q_ff, q_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [LINK_W-1:0] tl_ff, tl_in;
   logic [5:0]        res_task_ff, res_task_in;
   logic [1:0]        res_lvl_ff, res_lvl_in;
   logic [15:0]       res_slice_ff, res_slice_in;
   logic              res_found_ff, res_found_in;
   logic [CW-1:0]     left_ff, left_in;
   logic [LINK_W-1:0] head_ff [NUM_LEVELS];
   logic [LINK_W-1:0] head_in [NUM_LEVELS];
   logic [LINK_W-1:0] tail_ff [NUM_LEVELS];
   logic [LINK_W-1:0] tail_in [NUM_LEVELS];
   logic [CW-1:0]     cnt_ff  [NUM_LEVELS];
   logic [CW-1:0]     cnt_in  [NUM_LEVELS];
   logic [CW-1:0]     total_ff, total_in;
   logic [NUM_TASKS-1:0] queued_ff, queued_in;
   logic [15:0]       slice_ff [NUM_SLICES];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [TW-1:0]     rd_addr;
   logic [LINK_W-1:0] rd_next, rd_prev;
   logic [LW-1:0]     rd_level;
   link_we_type       wr_en;
   logic [TW-1:0]     next_addr, prev_addr, level_addr;
   logic [LINK_W-1:0] next_data, prev_data;
   logic [LW-1:0]     level_data;

   logic              pick_hit, boost_hit;
   logic [LW-1:0]     pick_lvl, boost_lvl;
   logic [CW-1:0]     cnt_sum;

   mlfq_link_mem #(
      .NUM_TASKS (NUM_TASKS),
      .NUM_LEVELS(NUM_LEVELS)
   ) u_link_mem (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_next   (rd_next),
      .rd_prev   (rd_prev),
      .rd_level  (rd_level),
      .wr_en     (wr_en),
      .next_addr (next_addr),
      .next_data (next_data),
      .prev_addr (prev_addr),
      .prev_data (prev_data),
      .level_addr(level_addr),
      .level_data(level_data)
   );

   function automatic logic [15:0] slice_of(input logic [LW-1:0] l,
                                            input logic [15:0] s0,
                                            input logic [15:0] s1,
                                            input logic [15:0] s2,
                                            input logic [15:0] s3);
      logic [15:0] r;
      if (32'(l) == 0) begin
         r = s0;
      end else if (32'(l) == 1) begin
         r = s1;
      end else if (32'(l) == 2) begin
         r = s2;
      end else begin
         r = s3;
      end
      return r;
   endfunction

   always_comb begin
      pick_hit  = 1'b0;
      pick_lvl  = '0;
      boost_hit = 1'b0;
      boost_lvl = '0;
      cnt_sum   = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (head_ff[i] != NIL) begin
            pick_hit = 1'b1;
            pick_lvl = LW'(i);
            if (i > 0) begin
               boost_hit = 1'b1;
               boost_lvl = LW'(i);
            end
         end
      end
      for (int i = 0; i < NUM_LEVELS; i++) begin
         cnt_sum = cnt_sum + cnt_ff[i];
      end
   end

   always_comb begin
      logic          t_ok;
      logic [TW-1:0] t_idx;
      logic [LW-1:0] clamp_lvl;
      logic          do_unlink;
      logic [CW-1:0] q_cnt;
      state_in     = state_ff;
      op_in        = op_ff;
      task_in      = task_ff;
      q_in         = q_ff;
      lvl_in       = lvl_ff;
      tl_in        = tl_ff;
      res_task_in  = res_task_ff;
      res_lvl_in   = res_lvl_ff;
      res_slice_in = res_slice_ff;
      res_found_in = res_found_ff;
      left_in      = left_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      queued_in    = queued_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = task_ff;
      wr_en        = '0;
      next_addr    = task_ff;
      next_data    = NIL;
      prev_addr    = task_ff;
      prev_data    = NIL;
      level_addr   = task_ff;
      level_data   = lvl_ff;
      t_ok         = 32'(req_payload.task_number) < NUM_TASKS;
      t_idx        = TW'(req_payload.task_number);
      clamp_lvl    = (32'(req_payload.requested_level) > NUM_LEVELS - 1) ?
                     LW'(NUM_LEVELS - 1) : LW'(req_payload.requested_level);
      do_unlink    = 1'b0;
      q_cnt        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = t_idx;
            if (req_valid) begin
               op_in        = req_payload.action;
               task_in      = t_idx;
               q_in         = req_payload.query_level;
               res_task_in  = '0;
               res_lvl_in   = '0;
               res_slice_in = '0;
               res_found_in = 1'b0;
               state_in     = ST_EMIT;
               priority if ((req_payload.action == ACT_ENQUEUE ||
                             req_payload.action == ACT_REMOVE ||
                             req_payload.action == ACT_DEMOTE) && !t_ok) begin
                  state_in = ST_EMIT;
               end else if (req_payload.action == ACT_ENQUEUE) begin
                  res_task_in = req_payload.task_number;
                  if (queued_ff[t_idx]) begin
                     state_in = ST_LOOKUP;
                  end else begin
                     lvl_in       = clamp_lvl;
                     res_lvl_in   = 2'(clamp_lvl);
                     res_found_in = 1'b1;
                     state_in     = ST_APPEND_A;
                  end
               end else if (req_payload.action == ACT_REMOVE) begin
                  res_task_in = req_payload.task_number;
                  if (queued_ff[t_idx]) begin
                     state_in = ST_LOOKUP;
                  end
               end else if (req_payload.action == ACT_DEMOTE) begin
                  state_in = ST_LOOKUP;
               end else if (req_payload.action == ACT_BOOST) begin
                  left_in = total_ff - cnt_ff[0];
                  if (total_ff != cnt_ff[0]) begin
                     state_in = ST_BOOST;
                  end
               end else if (req_payload.action == ACT_PICK) begin
                  if (pick_hit) begin
                     task_in    = head_ff[pick_lvl][TW-1:0];
                     rd_addr    = head_ff[pick_lvl][TW-1:0];
                     res_lvl_in = 2'(pick_lvl);
                     state_in   = ST_LOOKUP;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BOOST: begin
            task_in  = head_ff[boost_lvl][TW-1:0];
            rd_addr  = head_ff[boost_lvl][TW-1:0];
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            res_task_in = 6'(task_ff);
            do_unlink   = (op_ff != ACT_ENQUEUE) &&
                          (op_ff != ACT_DEMOTE || queued_ff[task_ff]);
            if (do_unlink) begin
               if (rd_prev != NIL) begin
                  wr_en.next_we = 1'b1;
                  next_addr     = rd_prev[TW-1:0];
                  next_data     = rd_next;
               end else begin
                  head_in[rd_level] = rd_next;
               end
               if (rd_next != NIL) begin
                  wr_en.prev_we = 1'b1;
                  prev_addr     = rd_next[TW-1:0];
                  prev_data     = rd_prev;
               end else begin
                  tail_in[rd_level] = rd_prev;
               end
               cnt_in[rd_level]   = cnt_ff[rd_level] - 1'b1;
               total_in           = total_ff - 1'b1;
               queued_in[task_ff] = 1'b0;
            end
            priority if (op_ff == ACT_ENQUEUE) begin
               res_lvl_in = 2'(rd_level);
               state_in   = ST_EMIT;
            end else if (op_ff == ACT_REMOVE) begin
               res_lvl_in   = 2'(rd_level);
               res_found_in = 1'b1;
               state_in     = ST_EMIT;
            end else if (op_ff == ACT_PICK) begin
               res_found_in = 1'b1;
               state_in     = ST_EMIT;
            end else if (op_ff == ACT_DEMOTE) begin
               lvl_in   = (32'(rd_level) < NUM_LEVELS - 1) ? rd_level + 1'b1 : rd_level;
               state_in = ST_APPEND_A;
            end else begin
               lvl_in   = '0;
               state_in = ST_APPEND_A;
            end
         end
         ST_APPEND_A: begin
            tl_in          = tail_ff[lvl_ff];
            wr_en          = '{next_we: 1'b1, prev_we: 1'b1, level_we: 1'b1};
            next_addr      = task_ff;
            next_data      = NIL;
            prev_addr      = task_ff;
            prev_data      = tail_ff[lvl_ff];
            tail_in[lvl_ff] = LINK_W'(task_ff);
            cnt_in[lvl_ff] = cnt_ff[lvl_ff] + 1'b1;
            total_in       = total_ff + 1'b1;
            queued_in[task_ff] = 1'b1;
            res_lvl_in     = 2'(lvl_ff);
            res_found_in   = 1'b1;
            res_slice_in   = (op_ff == ACT_ENQUEUE) ? 16'd0 :
                             slice_of(lvl_ff, slice_ff[0], slice_ff[1],
                                      slice_ff[2], slice_ff[3]);
            state_in       = ST_APPEND_B;
         end
         ST_APPEND_B: begin
            if (tl_ff != NIL) begin
               wr_en.next_we = 1'b1;
               next_addr     = tl_ff[TW-1:0];
               next_data     = LINK_W'(task_ff);
            end else begin
               head_in[lvl_ff] = LINK_W'(task_ff);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (32'(q_ff) < NUM_LEVELS) begin
               if (op_ff == ACT_BOOST) begin
                  q_cnt = (q_ff == 2'd0) ? total_ff : '0;
               end else begin
                  q_cnt = cnt_ff[LW'(q_ff)];
               end
            end
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.result_task   = res_task_ff;
               rsp_data_in.result_level  = res_lvl_ff;
               rsp_data_in.granted_slice = res_slice_ff;
               rsp_data_in.found         = res_found_ff;
               rsp_data_in.level_count   = 7'(q_cnt);
               rsp_data_in.last          = 1'b1;
               state_in                  = ST_IDLE;
               if (op_ff == ACT_BOOST && res_found_ff && left_ff != CW'(1)) begin
                  rsp_data_in.last = 1'b0;
                  left_in          = left_ff - 1'b1;
                  state_in         = ST_BOOST;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         queued_ff    <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
            cnt_ff[i]  <= '0;
         end
         slice_ff[0] <= SLICE0_RESET;
         slice_ff[1] <= SLICE1_RESET;
         slice_ff[2] <= SLICE2_RESET;
         slice_ff[3] <= SLICE3_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         queued_ff    <= queued_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         if (psel && penable && pwrite) begin
            slice_ff[paddr[3:2]] <= pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      task_ff      <= task_in;
      q_ff         <= q_in;
      lvl_ff       <= lvl_in;
      tl_ff        <= tl_in;
      res_task_ff  <= res_task_in;
      res_lvl_ff   <= res_lvl_in;
      res_slice_ff <= res_slice_in;
      res_found_ff <= res_found_in;
      left_ff      <= left_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign pready      = 1'b1;
   assign prdata      = {16'd0, slice_ff[paddr[3:2]]};

   a_total_matches_levels: assert property (@(posedge clock) disable iff (reset)
      total_ff == cnt_sum)
      else $error("level counts disagree with total");

   a_total_matches_marks: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_ff) == 32'(total_ff))
      else $error("queued marks disagree with total");

   a_append_unqueued: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPEND_A |-> !queued_ff[task_ff])
      else $error("append of a queued task");

   a_boost_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BOOST |-> boost_hit && left_ff != '0)
      else $error("boost step with nothing to move");

endmodule
`default_nettype wire
